// ----- rtl/core/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg : process slot table shared definitions
// Operation and phase codes, beat payload structs and default sizes.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int SLOTS_DEF    = 64;
    localparam int PID_BITS_DEF = 32;

    // operation codes
    localparam logic [1:0] OP_SPAWN = 2'd0;
    localparam logic [1:0] OP_EXIT  = 2'd1;
    localparam logic [1:0] OP_WAIT  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // slot phase codes
    localparam logic [1:0] PH_FREE    = 2'd0;
    localparam logic [1:0] PH_READY   = 2'd1;
    localparam logic [1:0] PH_RUNNING = 2'd2;
    localparam logic [1:0] PH_ZOMBIE  = 2'd3;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        target_id;
        logic signed [31:0] exit_value;
    } t_in;

    typedef struct packed {
        logic               status;
        logic [31:0]        new_id;
        logic signed [31:0] reaped_value;
        logic [1:0]         slot_status;
    } t_out;

    // per-field write enables of the slot table
    typedef struct packed {
        logic id;
        logic phase;
        logic code;
    } t_wr_en;

endpackage

// ----- rtl/core/pst_table.sv -----
// ----------------------------------------------------------------------------
// pst_table : slot storage
// Id, phase and exit code memories; one write port, one registered read port.
// ----------------------------------------------------------------------------
module pst_table #(
    parameter int SLOTS    = pst_pkg::SLOTS_DEF,
    parameter int PID_BITS = pst_pkg::PID_BITS_DEF,
    parameter int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                i_clk,
    input  pst_pkg::t_wr_en     i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [PID_BITS-1:0] i_wr_id,
    input  logic [1:0]          i_wr_phase,
    input  logic [31:0]         i_wr_code,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [PID_BITS-1:0] o_rd_id,
    output logic [1:0]          o_rd_phase,
    output logic [31:0]         o_rd_code
);
    import pst_pkg::*;

    logic [PID_BITS-1:0] mem_id    [SLOTS];
    logic [1:0]          mem_phase [SLOTS];
    logic [31:0]         mem_code  [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en.id) begin
            mem_id[i_wr_addr] <= i_wr_id;
        end
        if (i_wr_en.phase) begin
            mem_phase[i_wr_addr] <= i_wr_phase;
        end
        if (i_wr_en.code) begin
            mem_code[i_wr_addr] <= i_wr_code;
        end
        o_rd_id    <= mem_id[i_rd_addr];
        o_rd_phase <= mem_phase[i_rd_addr];
        o_rd_code  <= mem_code[i_rd_addr];
    end

endmodule

// ----- rtl/core/process_slot_table.sv -----
// ----------------------------------------------------------------------------
// process_slot_table : process slot allocator and lookup
// Spawn, exit, wait and query over a table of process slots.
// ----------------------------------------------------------------------------
// Usage:
//   One request beat goes in on i_in_* (valid/ready), one result beat comes
//   out on o_out_* (valid/ready) for every request.
//   A request is scanned slot by slot through a single compare unit: the
//   slot memories are read one entry a cycle, the registered read data is
//   compared with the request, and the scan stops at the first hit.
//   Throughput is one request per scan: a new request is taken only once
//   the previous scan result has moved to the output register. The memory
//   read port, one entry a cycle, sets the length of a scan.
//   After reset the block runs a clearing pass over the phase memory, with
//   o_in_ready low; afterwards all slots are free and the pid counter is
//   zero.
//   A result beat waits in the output register while the receiver stalls;
//   the next request is taken meanwhile, and its scan result is held until
//   the output register empties.
// ----------------------------------------------------------------------------
module process_slot_table #(
    parameter int SLOTS    = pst_pkg::SLOTS_DEF,
    parameter int PID_BITS = pst_pkg::PID_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pst_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pst_pkg::t_out o_out_data
);
    import pst_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // compare width: ids and target ids zero-extended to a common width
    localparam int CW = (PID_BITS > 32) ? PID_BITS : 32;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;     // read (or clear) address
    logic [AW-1:0]       r_didx, n_didx;     // slot index of the read data
    logic                r_dv, n_dv;         // read data valid
    logic [PID_BITS-1:0] r_ctr, n_ctr;       // pid counter
    t_in                 r_req, n_req;       // request under work
    t_out                r_pend, n_pend;     // scan result waiting for output
    logic                r_ovalid, n_ovalid;
    t_out                r_out, n_out;

    t_wr_en              wr_en;
    logic [AW-1:0]       wr_addr;
    logic [PID_BITS-1:0] wr_id;
    logic [1:0]          wr_phase;
    logic [31:0]         wr_code;
    logic [PID_BITS-1:0] rd_id;
    logic [1:0]          rd_phase;
    logic [31:0]         rd_code;

    logic                hit;
    logic                out_free;
    logic [PID_BITS-1:0] spawn_id;

    pst_table #(
        .SLOTS    (SLOTS),
        .PID_BITS (PID_BITS),
        .AW       (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_id    (wr_id),
        .i_wr_phase (wr_phase),
        .i_wr_code  (wr_code),
        .i_rd_addr  (r_addr),
        .o_rd_id    (rd_id),
        .o_rd_phase (rd_phase),
        .o_rd_code  (rd_code)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign out_free    = !r_ovalid || i_out_ready;
    assign spawn_id    = r_ctr + 1'b1;

    // shared compare unit: spawn looks for a free slot, the rest for a live id
    always_comb begin
        if (r_req.operation == OP_SPAWN) begin
            hit = (rd_phase == PH_FREE);
        end else begin
            hit = (rd_phase != PH_FREE) && (CW'(rd_id) == CW'(r_req.target_id));
        end
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_didx   = r_didx;
        n_dv     = 1'b0;
        n_ctr    = r_ctr;
        n_req    = r_req;
        n_pend   = r_pend;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        wr_en    = '0;
        wr_addr  = r_didx;
        wr_id    = '0;
        wr_phase = PH_FREE;
        wr_code  = '0;

        // drain the output register
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // sweep the phase memory to free, one slot a cycle
                wr_en.phase = 1'b1;
                wr_addr     = r_addr;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_addr  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // advance the read address, hold at the last slot
                n_didx = r_addr;
                n_dv   = 1'b1;
                if (r_addr != LAST) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_dv) begin
                    n_pend.status       = ST_FAIL;
                    n_pend.new_id       = '0;
                    n_pend.reaped_value = '0;
                    n_pend.slot_status  = PH_FREE;
                    if (hit) begin
                        n_state = S_HOLD;
                        case (r_req.operation)
                            OP_SPAWN: begin
                                n_ctr         = spawn_id;
                                wr_en         = '{id: 1'b1, phase: 1'b1, code: 1'b1};
                                wr_id         = spawn_id;
                                wr_phase      = PH_READY;
                                wr_code       = '0;
                                n_pend.status = ST_OK;
                                n_pend.new_id = 32'(spawn_id);
                            end
                            OP_EXIT: begin
                                if (rd_phase inside {PH_READY, PH_RUNNING}) begin
                                    wr_en.phase   = 1'b1;
                                    wr_en.code    = 1'b1;
                                    wr_phase      = PH_ZOMBIE;
                                    wr_code       = r_req.exit_value;
                                    n_pend.status = ST_OK;
                                end
                            end
                            OP_WAIT: begin
                                if (rd_phase == PH_ZOMBIE) begin
                                    wr_en.phase         = 1'b1;
                                    wr_en.id            = 1'b1;
                                    wr_phase            = PH_FREE;
                                    wr_id               = '0;
                                    n_pend.status       = ST_OK;
                                    n_pend.reaped_value = rd_code;
                                end
                            end
                            default: begin
                                n_pend.status      = ST_OK;
                                n_pend.slot_status = rd_phase;
                            end
                        endcase
                    end else if (r_didx == LAST) begin
                        // whole table scanned without a hit
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                // move the result to the output register once it is free
                if (out_free) begin
                    n_out    = r_pend;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_dv     <= 1'b0;
            r_ctr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_dv     <= n_dv;
            r_ctr    <= n_ctr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= n_didx;
        r_req  <= n_req;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

endmodule
